// File: design/wide_mul_div_rem_pow_assert.svh
// Assertion macros shared by the wide multiply / divide / power design.
`ifndef WIDE_MUL_DIV_REM_POW_ASSERT_SVH
`define WIDE_MUL_DIV_REM_POW_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WMDRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WMDRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wmdrp_pkg.sv
// Package: sizes, payload types, operation codes and helper functions.
package wmdrp_pkg;

    localparam int MAX_WORDS = 4;
    localparam int WORD_W    = 64;
    localparam int NBITS     = MAX_WORDS * WORD_W;
    localparam int WIDTH_W   = 9;
    localparam int BIT_IDX_W = $clog2(NBITS);
    localparam int LOAD_W    = $clog2(MAX_WORDS + 1);
    localparam int WSEL_W    = $clog2(MAX_WORDS);
    localparam int WORD_SH   = $clog2(WORD_W);

    typedef enum logic [1:0] {
        MODE_MUL = 2'd0,
        MODE_DIV = 2'd1,
        MODE_REM = 2'd2,
        MODE_POW = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [63:0]        lhs_word;
        logic [63:0]        rhs_word;
        logic [WIDTH_W-1:0] lhs_width;
        logic [WIDTH_W-1:0] rhs_width;
        logic               lhs_signed;
        logic               rhs_signed;
        logic [WIDTH_W-1:0] result_width;
        logic               last_in;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_word;
        logic        undefined;
        logic        result_signed;
        logic        last_out;
    } out_word_t;

    // Map a width of zero to one and anything above the operand size to the size.
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        if (w == '0) begin
            r = WIDTH_W'(1);
        end else if (w > WIDTH_W'(NBITS)) begin
            r = WIDTH_W'(NBITS);
        end else begin
            r = w;
        end
        return r;
    endfunction

    // Ones in bit positions below w.
    function automatic logic [NBITS-1:0] width_mask(input logic [WIDTH_W-1:0] w);
        logic [NBITS-1:0] m;
        for (int i = 0; i < NBITS; i++) begin
            m[i] = (WIDTH_W'(i) < w);
        end
        return m;
    endfunction

    // Read src at srcw bits, sign or zero extend, truncate to width bits.
    function automatic logic [NBITS-1:0] extend(input logic [NBITS-1:0]   src,
                                                input logic [WIDTH_W-1:0] srcw,
                                                input logic [WIDTH_W-1:0] width,
                                                input logic               sgn);
        logic [NBITS-1:0]     ms;
        logic [NBITS-1:0]     r;
        logic [BIT_IDX_W-1:0] top;
        ms  = width_mask(srcw);
        top = BIT_IDX_W'(srcw - WIDTH_W'(1));
        r   = src & ms;
        if (sgn && src[top]) begin
            r = r | ~ms;
        end
        return r & width_mask(width);
    endfunction

endpackage

// File: design/wide_mul_div_rem_pow.sv
// Top level: multiword multiply, divide, remainder and power unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | in_word_t: one operand word pair
//  m_      | out       | m_valid / m_ready  | out_word_t: one result word
//
// Operand words load one per cycle while idle; the word marked last_in starts
// the operation and the unit drops s_ready until the final result word leaves.
// All arithmetic runs through one shared 258-bit adder under the sequencer:
//   multiply  : shift-add over the significant multiplier bits (at most 256)
//   divide/rem: result_width quotient steps (one quotient bit per cycle)
//   power     : up to two shift-add multiplies per exponent bit
// then the result words, each leaving when m_ready takes it.
// Reset (aresetn low, synchronous) returns the sequencer to idle and empties
// the operand load count; operand stores need no reset.
module wide_mul_div_rem_pow (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wmdrp_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wmdrp_pkg::out_word_t m_data
);

    localparam int NB    = wmdrp_pkg::NBITS;
    localparam int WW    = wmdrp_pkg::WIDTH_W;
    localparam int BIW   = wmdrp_pkg::BIT_IDX_W;
    localparam int LW    = wmdrp_pkg::LOAD_W;
    localparam int SW    = wmdrp_pkg::WSEL_W;
    localparam int WDW   = wmdrp_pkg::WORD_W;
    localparam int MAXW  = wmdrp_pkg::MAX_WORDS;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_EXT    = 12'b0000_0000_0010,
        ST_NEGA   = 12'b0000_0000_0100,
        ST_NEGB   = 12'b0000_0000_1000,
        ST_POWCHK = 12'b0000_0001_0000,
        ST_PSTEP  = 12'b0000_0010_0000,
        ST_MUL    = 12'b0000_0100_0000,
        ST_DIV    = 12'b0000_1000_0000,
        ST_DIVEND = 12'b0001_0000_0000,
        ST_FIX    = 12'b0010_0000_0000,
        ST_FIN    = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [WDW-1:0]    lstore_reg [MAXW];
    logic [WDW-1:0]    rstore_reg [MAXW];
    logic [LW-1:0]     load_cnt_reg, load_cnt_next;
    wmdrp_pkg::mode_t  mode_reg, mode_next;
    logic [WW-1:0]     lw_reg, lw_next, rw_reg, rw_next, w_reg, w_next;
    logic              ls_reg, ls_next, rs_reg, rs_next;
    logic [NB-1:0]     opa_reg, opa_next, opb_reg, opb_next;
    logic [NB-1:0]     acc_reg, acc_next, rem_reg, rem_next;
    logic [NB-1:0]     ma_reg, ma_next, mb_reg, mb_next, mp_reg, mp_next;
    logic [WW-1:0]     cnt_reg, cnt_next;
    logic              undef_reg, undef_next, rsig_reg, rsig_next;
    logic              ln_reg, ln_next, rn_reg, rn_next, neg_reg, neg_next;
    logic              sq_reg, sq_next;
    logic [SW-1:0]     oidx_reg, oidx_next, nw_last_reg, nw_last_next;

    logic              in_fire, out_fire;
    logic [NB-1:0]     lsrc, rsrc, rsrc_m, ext_a, ext_b, wmask_w, mask_rw, one_v, mul_res;
    logic [BIW-1:0]    w_top, rw_top, div_idx;
    logic [NB:0]       div_sh, add_a, add_b;
    logic              add_cin;
    logic [NB+1:0]     add_sum;
    logic              div_ge;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);

    assign m_data.result_word   = acc_reg[WDW * oidx_reg +: WDW];
    assign m_data.undefined     = undef_reg;
    assign m_data.result_signed = rsig_reg;
    assign m_data.last_out      = (oidx_reg == nw_last_reg);

    // Assemble operands; words past the load count read as zero.
    always_comb begin
        for (int i = 0; i < MAXW; i++) begin
            lsrc[i*WDW +: WDW] = (LW'(i) < load_cnt_reg) ? lstore_reg[i] : '0;
            rsrc[i*WDW +: WDW] = (LW'(i) < load_cnt_reg) ? rstore_reg[i] : '0;
        end
    end

    assign wmask_w = wmdrp_pkg::width_mask(w_reg);
    assign mask_rw = wmdrp_pkg::width_mask(rw_reg);
    assign one_v   = NB'(1);
    assign w_top   = BIW'(w_reg - WW'(1));
    assign rw_top  = BIW'(rw_reg - WW'(1));
    assign div_idx = BIW'(cnt_reg - WW'(1));
    assign rsrc_m  = rsrc & mask_rw;
    assign mul_res = mp_reg & wmask_w;
    assign div_sh  = {rem_reg, opa_reg[div_idx]};

    always_comb begin
        if (mode_reg == wmdrp_pkg::MODE_POW) begin
            ext_a = wmdrp_pkg::extend(lsrc, lw_reg, w_reg, ls_reg);
            ext_b = rsrc_m;
        end else begin
            ext_a = wmdrp_pkg::extend(lsrc, lw_reg, w_reg, ls_reg && rs_reg);
            ext_b = wmdrp_pkg::extend(rsrc, rw_reg, w_reg, ls_reg && rs_reg);
        end
    end

    // Shared adder: negate, accumulate partial products, trial subtract.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (state_reg)
            ST_NEGA: begin
                add_a   = {1'b0, ~opa_reg};
                add_cin = 1'b1;
            end
            ST_NEGB: begin
                add_a   = {1'b0, ~opb_reg};
                add_cin = 1'b1;
            end
            ST_MUL: begin
                add_a = {1'b0, mp_reg};
                add_b = {1'b0, ma_reg};
            end
            ST_DIV: begin
                add_a   = div_sh;
                add_b   = ~{1'b0, opb_reg};
                add_cin = 1'b1;
            end
            ST_FIX: begin
                add_a   = {1'b0, ~acc_reg};
                add_cin = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (NB+2)'(add_cin);
    assign div_ge  = add_sum[NB+1];

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        mode_next     = mode_reg;
        lw_next       = lw_reg;
        rw_next       = rw_reg;
        w_next        = w_reg;
        ls_next       = ls_reg;
        rs_next       = rs_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        mp_next       = mp_reg;
        cnt_next      = cnt_reg;
        undef_next    = undef_reg;
        rsig_next     = rsig_reg;
        ln_next       = ln_reg;
        rn_next       = rn_reg;
        neg_next      = neg_reg;
        sq_next       = sq_reg;
        oidx_next     = oidx_reg;
        nw_last_next  = nw_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (load_cnt_reg < LW'(MAXW)) begin
                        load_cnt_next = load_cnt_reg + LW'(1);
                    end
                    if (s_data.last_in) begin
                        mode_next  = s_data.mode;
                        lw_next    = wmdrp_pkg::clamp_width(s_data.lhs_width);
                        rw_next    = wmdrp_pkg::clamp_width(s_data.rhs_width);
                        w_next     = wmdrp_pkg::clamp_width(s_data.result_width);
                        ls_next    = s_data.lhs_signed;
                        rs_next    = s_data.rhs_signed;
                        undef_next = 1'b0;
                        state_next = ST_EXT;
                    end
                end
            end
            ST_EXT: begin
                opa_next = ext_a;
                opb_next = ext_b;
                if (mode_reg == wmdrp_pkg::MODE_POW) begin
                    rsig_next  = ls_reg;
                    rn_next    = rs_reg && rsrc_m[rw_top];
                    state_next = ST_NEGB;
                end else begin
                    rsig_next = ls_reg && rs_reg;
                    ln_next   = ls_reg && rs_reg && ext_a[w_top];
                    rn_next   = ls_reg && rs_reg && ext_b[w_top];
                    if (mode_reg == wmdrp_pkg::MODE_MUL) begin
                        ma_next    = ext_a;
                        mb_next    = ext_b;
                        mp_next    = '0;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_NEGA;
                    end
                end
            end
            ST_NEGA: begin
                if (ln_reg) begin
                    opa_next = add_sum[NB-1:0] & wmask_w;
                end
                state_next = ST_NEGB;
            end
            ST_NEGB: begin
                if (rn_reg) begin
                    opb_next = add_sum[NB-1:0] &
                               ((mode_reg == wmdrp_pkg::MODE_POW) ? mask_rw : wmask_w);
                end
                if (mode_reg == wmdrp_pkg::MODE_POW) begin
                    state_next = ST_POWCHK;
                end else if (opb_reg == '0) begin
                    undef_next = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = w_reg;
                    state_next = ST_DIV;
                end
            end
            ST_POWCHK: begin
                if (opb_reg == '0) begin
                    acc_next   = one_v;
                    state_next = ST_FIN;
                end else if (rn_reg) begin
                    if (opa_reg == '0) begin
                        undef_next = 1'b1;
                    end else if (opa_reg == one_v) begin
                        acc_next = one_v;
                    end else if (ls_reg && (opa_reg == wmask_w)) begin
                        acc_next = opb_reg[0] ? wmask_w : one_v;
                    end else begin
                        acc_next = '0;
                    end
                    state_next = ST_FIN;
                end else begin
                    acc_next   = one_v;
                    state_next = ST_PSTEP;
                end
            end
            ST_PSTEP: begin
                // Stop once the remaining exponent bits are all zero.
                if (opb_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    ma_next    = opb_reg[0] ? acc_reg : opa_reg;
                    mb_next    = opa_reg;
                    mp_next    = '0;
                    sq_next    = !opb_reg[0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mb_reg != '0) begin
                    if (mb_reg[0]) begin
                        mp_next = add_sum[NB-1:0];
                    end
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg >> 1;
                end else if (mode_reg != wmdrp_pkg::MODE_POW) begin
                    acc_next   = mul_res;
                    state_next = ST_FIN;
                end else if (!sq_reg) begin
                    // Multiply into the result done; square the base next.
                    acc_next = mul_res;
                    ma_next  = opa_reg;
                    mb_next  = opa_reg;
                    mp_next  = '0;
                    sq_next  = 1'b1;
                end else begin
                    opa_next   = mul_res;
                    opb_next   = opb_reg >> 1;
                    state_next = ST_PSTEP;
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? add_sum[NB-1:0] : div_sh[NB-1:0];
                acc_next = {acc_reg[NB-2:0], div_ge};
                cnt_next = cnt_reg - WW'(1);
                if (cnt_reg == WW'(1)) begin
                    state_next = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                if (mode_reg == wmdrp_pkg::MODE_REM) begin
                    acc_next = rem_reg;
                    neg_next = ln_reg;
                end else begin
                    neg_next = ln_reg ^ rn_reg;
                end
                state_next = ST_FIX;
            end
            ST_FIX: begin
                if (neg_reg) begin
                    acc_next = add_sum[NB-1:0];
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                acc_next     = undef_reg ? '0 : (acc_reg & wmask_w);
                oidx_next    = '0;
                nw_last_next = SW'((w_reg - WW'(1)) >> wmdrp_pkg::WORD_SH);
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) begin
                    if (oidx_reg == nw_last_reg) begin
                        load_cnt_next = '0;
                        state_next    = ST_IDLE;
                    end else begin
                        oidx_next = oidx_reg + SW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Operand stores: write the incoming word pair while slots remain.
    always_ff @(posedge aclk) begin
        if (in_fire && (load_cnt_reg < LW'(MAXW))) begin
            lstore_reg[load_cnt_reg[SW-1:0]] <= s_data.lhs_word;
            rstore_reg[load_cnt_reg[SW-1:0]] <= s_data.rhs_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            load_cnt_reg <= '0;
            oidx_reg     <= '0;
            nw_last_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            oidx_reg     <= oidx_next;
            nw_last_reg  <= nw_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        lw_reg    <= lw_next;
        rw_reg    <= rw_next;
        w_reg     <= w_next;
        ls_reg    <= ls_next;
        rs_reg    <= rs_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        mp_reg    <= mp_next;
        cnt_reg   <= cnt_next;
        undef_reg <= undef_next;
        rsig_reg  <= rsig_next;
        ln_reg    <= ln_next;
        rn_reg    <= rn_next;
        neg_reg   <= neg_next;
        sq_reg    <= sq_next;
    end

`include "wide_mul_div_rem_pow_assert.svh"

    `WMDRP_ASSERT_NOW(a_one_side, s_ready, !m_valid, "input taken while results pending")
    `WMDRP_ASSERT_NOW(a_undef, m_valid && m_data.undefined, m_data.result_word == '0, "undef word set")
    `WMDRP_ASSERT_NEXT(a_back_idle, out_fire && m_data.last_out, s_ready && load_cnt_reg == '0, "not idle")
    `WMDRP_ASSERT_NEXT(a_more_words, out_fire && !m_data.last_out, m_valid, "result words cut short")

endmodule

// File: tb/wide_mul_div_rem_pow_checker.sv
// Checker for the wide multiply / divide / power unit: predicts and compares result words.
`timescale 1ns / 100ps

module wide_mul_div_rem_pow_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  wmdrp_pkg::in_word_t  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  wmdrp_pkg::out_word_t m_data,
    output int                   errors,
    output int                   pending
);

    localparam int NB = wmdrp_pkg::NBITS;

    typedef logic [NB-1:0] wide_t;

    wide_t                lhs_store;
    wide_t                rhs_store;
    int                   words_loaded;
    wmdrp_pkg::out_word_t result_fifo[$];

    function automatic int fit_width(input logic [wmdrp_pkg::WIDTH_W-1:0] w);
        if (w == 0) return 1;
        if (w > NB) return NB;
        return int'(w);
    endfunction

    function automatic wide_t low_ones(input int w);
        if (w >= NB) return '1;
        return (wide_t'(1) << w) - wide_t'(1);
    endfunction

    function automatic wide_t resize(input wide_t src, input int srcw, input int w,
                                     input bit sgn);
        wide_t v;
        v = src & low_ones(srcw);
        if (sgn && v[srcw-1]) v = v | ~low_ones(srcw);
        return v & low_ones(w);
    endfunction

    // Evaluate one operation and queue its result words.
    task automatic predict_words(input wmdrp_pkg::in_word_t d);
        int                   lw, rw, w, nw;
        bit                   ls, rs, sg, ln, rn, neg, undef, rsig, eneg;
        wide_t                l, r, acc, base;
        wmdrp_pkg::out_word_t item;
        lw    = fit_width(d.lhs_width);
        rw    = fit_width(d.rhs_width);
        w     = fit_width(d.result_width);
        ls    = d.lhs_signed;
        rs    = d.rhs_signed;
        undef = 0;
        acc   = '0;
        if (d.mode == wmdrp_pkg::MODE_POW) begin
            rsig = ls;
            base = resize(lhs_store, lw, w, ls);
            r    = resize(rhs_store, rw, NB, 0);
            eneg = rs && r[rw-1];
            if (eneg) r = (-r) & low_ones(rw);
            if (r == '0) begin
                acc = wide_t'(1);
            end else if (eneg) begin
                // negative exponent: only unit bases survive
                if (base == '0) undef = 1;
                else if (base == wide_t'(1)) acc = wide_t'(1);
                else if (ls && base == low_ones(w)) acc = r[0] ? low_ones(w) : wide_t'(1);
                else acc = '0;
            end else begin
                acc = wide_t'(1);
                for (int k = 0; k < NB; k++) begin
                    if (r[k]) acc = acc * base;
                    base = base * base;
                end
            end
        end else begin
            sg   = ls && rs;
            rsig = sg;
            l    = resize(lhs_store, lw, w, sg);
            r    = resize(rhs_store, rw, w, sg);
            if (d.mode == wmdrp_pkg::MODE_MUL) begin
                acc = l * r;
            end else begin
                ln = sg && l[w-1];
                rn = sg && r[w-1];
                if (ln) l = (-l) & low_ones(w);
                if (rn) r = (-r) & low_ones(w);
                if (r == '0) begin
                    undef = 1;
                end else begin
                    // truncate toward zero; remainder follows the dividend
                    acc = (d.mode == wmdrp_pkg::MODE_REM) ? l % r : l / r;
                    neg = (d.mode == wmdrp_pkg::MODE_REM) ? ln : (ln != rn);
                    if (neg) acc = -acc;
                end
            end
        end
        if (undef) acc = '0;
        acc = acc & low_ones(w);
        nw  = (w + 63) / 64;
        for (int k = 0; k < nw; k++) begin
            item.result_word   = acc[64*k +: 64];
            item.undefined     = undef;
            item.result_signed = rsig;
            item.last_out      = (k == nw - 1);
            result_fifo.insert(result_fifo.size(), item);
        end
    endtask

    always @(posedge aclk) begin
        wmdrp_pkg::out_word_t exp_w;
        if (!aresetn) begin
            lhs_store    = '0;
            rhs_store    = '0;
            words_loaded = 0;
        end else begin
            if (s_valid && s_ready) begin
                // extra words past the store depth are dropped
                if (words_loaded < wmdrp_pkg::MAX_WORDS) begin
                    lhs_store[64*words_loaded +: 64] = s_data.lhs_word;
                    rhs_store[64*words_loaded +: 64] = s_data.rhs_word;
                    words_loaded++;
                end
                if (s_data.last_in) begin
                    predict_words(s_data);
                    lhs_store    = '0;
                    rhs_store    = '0;
                    words_loaded = 0;
                end
            end
            if (m_valid && m_ready) begin
                if (result_fifo.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word %h", m_data);
                end else begin
                    exp_w = result_fifo.pop_front();
                    if (m_data.result_word !== exp_w.result_word
                        || m_data.undefined !== exp_w.undefined
                        || m_data.result_signed !== exp_w.result_signed
                        || m_data.last_out !== exp_w.last_out) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: word exp %h got %h, undef exp %b got %b, ",
                                      "signed exp %b got %b, last exp %b got %b"},
                                     exp_w.result_word, m_data.result_word,
                                     exp_w.undefined, m_data.undefined,
                                     exp_w.result_signed, m_data.result_signed,
                                     exp_w.last_out, m_data.last_out);
                    end
                end
            end
        end
        pending <= result_fifo.size();
    end

    initial begin
        errors  = 0;
        pending = 0;
    end

endmodule

// File: tb/wide_mul_div_rem_pow_test.sv
// Testbench top: stimulus, handshake pacing and verdict for the wide multiply / power unit.
`timescale 1ns / 100ps

module wide_mul_div_rem_pow_test;

    typedef logic [wmdrp_pkg::NBITS-1:0] wide_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    wmdrp_pkg::in_word_t  s_data;
    logic                 m_valid;
    logic                 m_ready;
    wmdrp_pkg::out_word_t m_data;
    int                   errors;
    int                   pending;
    bit                   steady;      // when set, neither side idles
    bit                   done;

    wide_mul_div_rem_pow dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    wide_mul_div_rem_pow_checker checker_i (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .errors  (errors),
        .pending (pending)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mix of zero, all ones, small magnitudes of either sign and full random.
    function automatic wide_t pick_value();
        wide_t v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = wide_t'($urandom_range(1, 20));
            3: v = -wide_t'($urandom_range(1, 20));
            default: v = {rand64(), rand64(), rand64(), rand64()};
        endcase
        return v;
    endfunction

    // Hold valid and the word until accepted, then idle for a drawn gap.
    task automatic push_word(input wmdrp_pkg::in_word_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Send one operation as nwords word pairs; control fields of earlier words are noise.
    task automatic run_op(input wmdrp_pkg::mode_t md, input int nwords,
                          input wide_t lv, input wide_t rv,
                          input int lw, input int rw, input int w, input bit ls, input bit rs);
        wmdrp_pkg::in_word_t iw;
        for (int i = 0; i < nwords; i++) begin
            iw.mode         = wmdrp_pkg::mode_t'($urandom_range(0, 3));
            iw.lhs_width    = wmdrp_pkg::WIDTH_W'($urandom);
            iw.rhs_width    = wmdrp_pkg::WIDTH_W'($urandom);
            iw.result_width = wmdrp_pkg::WIDTH_W'($urandom);
            iw.lhs_signed   = 1'($urandom);
            iw.rhs_signed   = 1'($urandom);
            iw.lhs_word     = (i < wmdrp_pkg::MAX_WORDS) ? lv[64*i +: 64] : rand64();
            iw.rhs_word     = (i < wmdrp_pkg::MAX_WORDS) ? rv[64*i +: 64] : rand64();
            iw.last_in      = (i == nwords - 1);
            if (iw.last_in) begin
                iw.mode         = md;
                iw.lhs_width    = wmdrp_pkg::WIDTH_W'(lw);
                iw.rhs_width    = wmdrp_pkg::WIDTH_W'(rw);
                iw.result_width = wmdrp_pkg::WIDTH_W'(w);
                iw.lhs_signed   = ls;
                iw.rhs_signed   = rs;
            end
            push_word(iw);
        end
    endtask

    // Result side: stall for a drawn number of cycles before each word.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            @(posedge aclk);
        end
    end

    initial begin
        int               nwords, lw, rw, w;
        wmdrp_pkg::mode_t md;
        wide_t            lv, rv;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        steady  = 0;
        done    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The first op loads all four words.
        run_op(wmdrp_pkg::MODE_MUL, 4, '1, '1, 256, 256, 256, 1, 1);
        run_op(wmdrp_pkg::MODE_MUL, 4, '1, '1, 1, 1, 1, 0, 0);
        run_op(wmdrp_pkg::MODE_DIV, 2, wide_t'(99), '0, 64, 64, 64, 1, 1);   // zero divisor
        run_op(wmdrp_pkg::MODE_DIV, 4, -wide_t'(7), wide_t'(2), 256, 256, 256, 1, 1);
        run_op(wmdrp_pkg::MODE_REM, 4, -wide_t'(7), wide_t'(2), 256, 256, 256, 1, 1);
        run_op(wmdrp_pkg::MODE_REM, 1, wide_t'(7), -wide_t'(2), 64, 64, 64, 1, 1);
        run_op(wmdrp_pkg::MODE_DIV, 4, '1, wide_t'(1), 256, 256, 256, 0, 0);
        run_op(wmdrp_pkg::MODE_DIV, 1, wide_t'(8), wide_t'(8), 4, 4, 4, 1, 1); // -8 / -8
        run_op(wmdrp_pkg::MODE_POW, 1, wide_t'(5), '0, 64, 64, 64, 0, 0);   // zero exponent
        run_op(wmdrp_pkg::MODE_POW, 1, '0, '1, 64, 8, 64, 1, 1);            // zero base, neg exp
        run_op(wmdrp_pkg::MODE_POW, 1, wide_t'(1), '1, 64, 8, 64, 1, 1);
        run_op(wmdrp_pkg::MODE_POW, 1, '1, '1, 64, 8, 64, 1, 1);            // -1 to odd negative
        run_op(wmdrp_pkg::MODE_POW, 1, '1, -wide_t'(2), 64, 8, 64, 1, 1);   // -1 to even negative
        run_op(wmdrp_pkg::MODE_POW, 1, wide_t'(5), '1, 64, 8, 64, 1, 1);    // rounds to zero
        run_op(wmdrp_pkg::MODE_POW, 1, wide_t'(3), wide_t'(5), 64, 8, 64, 0, 0);
        run_op(wmdrp_pkg::MODE_POW, 2, -wide_t'(3), wide_t'(7), 128, 8, 128, 1, 0);
        run_op(wmdrp_pkg::MODE_MUL, 1, '1, '1, 0, 0, 0, 1, 1);          // width zero reads as one
        run_op(wmdrp_pkg::MODE_MUL, 4, '1, '1, 511, 511, 511, 0, 1);    // widths clamp to the top
        run_op(wmdrp_pkg::MODE_MUL, 6, '1, '1, 256, 256, 256, 1, 1);    // extra words dropped
        run_op(wmdrp_pkg::MODE_DIV, 1, '1, wide_t'(3), 256, 256, 256, 0, 0); // upper words zero
        run_op(wmdrp_pkg::MODE_POW, 4, {rand64(), rand64(), rand64(), rand64()},
               {rand64(), rand64(), rand64(), rand64()}, 256, 256, 256, 0, 0);

        for (int n = 0; n < 44; n++) begin
            if (n % 11 == 0) steady = ($urandom_range(0, 2) == 0);
            // Drain fully before sending more, now and then.
            if (n % 20 == 10) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                wait (pending == 0);
                @(posedge aclk);
            end
            md     = wmdrp_pkg::mode_t'($urandom_range(0, 3));
            nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            lv     = pick_value();
            rv     = pick_value();
            if ($urandom_range(0, 3) == 0) begin
                lw = $urandom_range(0, 511);
                rw = $urandom_range(0, 511);
                w  = $urandom_range(0, 511);
            end else begin
                lw = $urandom_range(1, 64 * nwords);
                rw = $urandom_range(1, 64 * nwords);
                w  = $urandom_range(1, 64 * nwords);
            end
            if (md == wmdrp_pkg::MODE_POW) begin
                // keep exponents short; each exponent bit costs up to two shift-add multiplies
                rw = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 96)
                                                  : $urandom_range(1, 16);
                if ($urandom_range(0, 3) == 0) lv = wide_t'($urandom_range(0, 3)) - wide_t'(1);
            end
            run_op(md, nwords, lv, rv, lw, rw, w, 1'($urandom), 1'($urandom));
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        done = 1;
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        if (!done) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

// File: wide_mul_div_rem_pow.f
+incdir+design
design/wmdrp_pkg.sv
design/wide_mul_div_rem_pow.sv
tb/wide_mul_div_rem_pow_checker.sv
tb/wide_mul_div_rem_pow_test.sv
